// ===== rtl/steering_safety_supervisor_defines.svh =====
// assertion macros for the steering safety supervisor
`ifndef STEERING_SAFETY_SUPERVISOR_DEFINES_SVH
`define STEERING_SAFETY_SUPERVISOR_DEFINES_SVH
`ifndef SYNTHESIS
`define SSS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("steering supervisor assertion failed");
`define SSS_ASSERT_IMPL(lbl, cond, expr) \
  `SSS_ASSERT(lbl, (cond) |-> (expr))
`else
`define SSS_ASSERT(lbl, prop)
`define SSS_ASSERT_IMPL(lbl, cond, expr)
`endif
`endif

// ===== rtl/sss_pkg.sv =====
// types and constants shared by the steering safety supervisor
package sss_pkg;

  localparam int unsigned ADDR_W = 5;

  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_SETPOINT = 2'd1;
  localparam logic [1:0] OP_FEEDBACK = 2'd2;
  localparam logic [1:0] OP_LIMIT    = 2'd3;

  localparam logic [2:0] REG_MAX_ANGLE   = 3'd0;
  localparam logic [2:0] REG_SERVO_ID    = 3'd1;
  localparam logic [2:0] REG_CURRENT_LIM = 3'd2;
  localparam logic [2:0] REG_CMD_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_FB_TIMEOUT  = 3'd4;

  localparam logic [14:0] MAX_ANGLE_RST   = 15'd2048;
  localparam logic [7:0]  SERVO_ID_RST    = 8'd1;
  localparam logic [15:0] CURRENT_LIM_RST = 16'd2000;
  localparam logic [15:0] TIMEOUT_RST     = 16'd25;

  localparam logic [15:0] AGE_MAX = 16'hFFFF;
  localparam logic signed [7:0] TEMP_SET = 8'sd85;
  localparam logic signed [7:0] TEMP_CLR = 8'sd80;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] setpoint_angle;
    logic               setpoint_finite;
    logic [7:0]         feedback_id;
    logic signed [15:0] feedback_position;
    logic [15:0]        feedback_errors;
    logic               feedback_torque_on;
    logic [15:0]        feedback_current_ma;
    logic signed [7:0]  feedback_temp_c;
    logic               limit_side;
    logic               limit_state;
    logic               limit_fault;
  } sss_in_t;

  typedef struct packed {
    logic               command_valid;
    logic signed [15:0] goal_angle;
    logic signed [15:0] target_angle;
    logic signed [15:0] current_angle;
    logic               servo_ok;
    logic               estop;
    logic               left_active;
    logic               right_active;
    logic               limits_ok;
    logic               position_ok;
    logic               system_ok;
    logic [15:0]        error_word;
  } sss_out_t;

  typedef struct packed {
    logic [14:0] max_angle;
    logic [7:0]  servo_id;
    logic [15:0] ilim_ma;
    logic [15:0] command_timeout_ticks;
    logic [15:0] feedback_timeout_ticks;
  } sss_cfg_t;

endpackage

// ===== rtl/steering_safety_supervisor.sv =====
// steering safety supervisor top level: event datapath and state
// Usage:
//   in_valid/in_ready/in_data carries one event request: a control tick, a
//   steering setpoint, a servo feedback report or a limit switch update.
//   out_valid/out_ready/out_data returns exactly one result per request: the
//   servo command (command_valid, goal_angle) and the status after the
//   update.
//   The apb port (psel ... pready) holds max angle, servo id, current limit
//   and the two timeouts at byte addresses 0, 4, 8, 12, 16; write only while
//   no request is in flight. pready is always high.
// Path: a request accepted into the input register passes through the update
//   logic and shows its result on out_data once it moves into the result
//   register. Throughput: one request per cycle while out_ready stays high;
//   each request reads the state left by the one before it, which is written
//   as it moves into the result register.
// Reset: rst_n (synchronous, low) empties both registers, clears all flags
//   and latches, marks limits ok, sets both ages to timed out and loads the
//   register defaults.
// Stall: while out_ready is low the result holds; one more request can wait
//   in the input register, after that in_ready drops.
module steering_safety_supervisor
  import sss_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sss_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sss_out_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

`include "steering_safety_supervisor_defines.svh"

  sss_cfg_t cfg;

  sss_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // pipeline registers
  logic     s1_valid_r;
  sss_in_t  s1_data_r;
  logic     out_valid_r;
  sss_out_t out_data_r;
  sss_out_t out_data_nxt;
  logic     advance;

  // supervisor state
  logic signed [15:0] target_r, target_nxt;
  logic signed [15:0] meas_r, meas_nxt;
  logic [15:0]        err_r, err_nxt;
  logic [15:0]        cur_r, cur_nxt;
  logic signed [7:0]  temp_r, temp_nxt;
  logic               healthy_r, healthy_nxt;
  logic               left_r, left_nxt;
  logic               right_r, right_nxt;
  logic               sens_ok_r, sens_ok_nxt;
  logic               oc_r, oc_nxt;
  logic               ot_r, ot_nxt;
  logic [15:0]        cmd_age_r, cmd_age_nxt;
  logic [15:0]        fb_age_r, fb_age_nxt;

  logic               cmd;
  logic signed [15:0] goal;
  logic               estop_cur;
  logic               estop_nxt;
  logic               pos_ok_nxt;

  // setpoint clamp
  logic signed [16:0] sp_ext, lim_pos, lim_neg, sp_clamp;
  logic signed [15:0] sp_val;
  logic               sp_safe;

  // tick checks
  logic [15:0] cmd_age_inc, fb_age_inc;
  logic [19:0] cur_x10, lim_x11, lim_x9;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sp_ext  = {s1_data_r.setpoint_angle[15], s1_data_r.setpoint_angle};
  assign lim_pos = signed'({2'b00, cfg.max_angle});
  assign lim_neg = -lim_pos;
  assign sp_clamp = (sp_ext > lim_pos) ? lim_pos :
                    (sp_ext < lim_neg) ? lim_neg : sp_ext;
  assign sp_val  = sp_clamp[15:0];
  assign sp_safe = !((sp_val < 16'sd0) && left_r) && !((sp_val > 16'sd0) && right_r);

  assign estop_cur = oc_r || ot_r || (err_r != 16'd0);

  assign cmd_age_inc = (cmd_age_r != AGE_MAX) ? cmd_age_r + 16'd1 : cmd_age_r;
  assign fb_age_inc  = (fb_age_r != AGE_MAX) ? fb_age_r + 16'd1 : fb_age_r;
  assign cur_x10 = {4'd0, cur_r} * 20'd10;
  assign lim_x11 = {4'd0, cfg.ilim_ma} * 20'd11;
  assign lim_x9  = {4'd0, cfg.ilim_ma} * 20'd9;

  always_comb begin
    target_nxt  = target_r;
    meas_nxt    = meas_r;
    err_nxt     = err_r;
    cur_nxt     = cur_r;
    temp_nxt    = temp_r;
    healthy_nxt = healthy_r;
    left_nxt    = left_r;
    right_nxt   = right_r;
    sens_ok_nxt = sens_ok_r;
    oc_nxt      = oc_r;
    ot_nxt      = ot_r;
    cmd_age_nxt = cmd_age_r;
    fb_age_nxt  = fb_age_r;
    cmd         = 1'b0;
    goal        = 16'sd0;
    case (s1_data_r.op)
      OP_SETPOINT: begin
        cmd_age_nxt = 16'd0;
        if (s1_data_r.setpoint_finite) begin
          target_nxt = sp_val;
          cmd        = 1'b1;
          goal       = (sp_safe && healthy_r && !estop_cur) ? sp_val : 16'sd0;
        end
      end
      OP_FEEDBACK: begin
        // reports from another servo are dropped
        if (s1_data_r.feedback_id == cfg.servo_id) begin
          fb_age_nxt  = 16'd0;
          meas_nxt    = s1_data_r.feedback_position;
          err_nxt     = s1_data_r.feedback_errors;
          cur_nxt     = s1_data_r.feedback_current_ma;
          temp_nxt    = s1_data_r.feedback_temp_c;
          healthy_nxt = (s1_data_r.feedback_errors == 16'd0) &&
                        s1_data_r.feedback_torque_on;
        end
      end
      OP_LIMIT: begin
        if (s1_data_r.limit_side) begin
          right_nxt = s1_data_r.limit_state;
        end else begin
          left_nxt = s1_data_r.limit_state;
        end
        sens_ok_nxt = !s1_data_r.limit_fault;
      end
      default: begin
        cmd_age_nxt = cmd_age_inc;
        fb_age_nxt  = fb_age_inc;
        if (cmd_age_inc > cfg.command_timeout_ticks) begin
          target_nxt = 16'sd0;
          cmd        = 1'b1;
        end
        if (fb_age_inc > cfg.feedback_timeout_ticks) begin
          healthy_nxt = 1'b0;
        end
        if (err_r != 16'd0) begin
          healthy_nxt = 1'b0;
          cmd         = 1'b1;
        end
        // hysteresis: set above 110 %, clear below 90 % of the limit
        if (cur_x10 > lim_x11) begin
          oc_nxt = 1'b1;
          cmd    = 1'b1;
        end else if (cur_x10 < lim_x9) begin
          oc_nxt = 1'b0;
        end
        if (temp_r > TEMP_SET) begin
          ot_nxt = 1'b1;
          cmd    = 1'b1;
        end else if (temp_r < TEMP_CLR) begin
          ot_nxt = 1'b0;
        end
      end
    endcase
  end

  assign estop_nxt  = oc_nxt || ot_nxt || (err_nxt != 16'd0);
  assign pos_ok_nxt = healthy_nxt && !(fb_age_nxt > cfg.feedback_timeout_ticks);

  always_comb begin
    out_data_nxt.command_valid = cmd;
    out_data_nxt.goal_angle    = cmd ? goal : 16'sd0;
    out_data_nxt.target_angle  = target_nxt;
    out_data_nxt.current_angle = meas_nxt;
    out_data_nxt.servo_ok      = healthy_nxt;
    out_data_nxt.estop         = estop_nxt;
    out_data_nxt.left_active   = left_nxt;
    out_data_nxt.right_active  = right_nxt;
    out_data_nxt.limits_ok     = sens_ok_nxt;
    out_data_nxt.position_ok   = pos_ok_nxt;
    out_data_nxt.system_ok     = healthy_nxt && sens_ok_nxt && !estop_nxt;
    out_data_nxt.error_word    = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      target_r    <= 16'sd0;
      meas_r      <= 16'sd0;
      err_r       <= 16'd0;
      cur_r       <= 16'd0;
      temp_r      <= 8'sd0;
      healthy_r   <= 1'b0;
      left_r      <= 1'b0;
      right_r     <= 1'b0;
      sens_ok_r   <= 1'b1;
      oc_r        <= 1'b0;
      ot_r        <= 1'b0;
      cmd_age_r   <= AGE_MAX;
      fb_age_r    <= AGE_MAX;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (advance) begin
        target_r  <= target_nxt;
        meas_r    <= meas_nxt;
        err_r     <= err_nxt;
        cur_r     <= cur_nxt;
        temp_r    <= temp_nxt;
        healthy_r <= healthy_nxt;
        left_r    <= left_nxt;
        right_r   <= right_nxt;
        sens_ok_r <= sens_ok_nxt;
        oc_r      <= oc_nxt;
        ot_r      <= ot_nxt;
        cmd_age_r <= cmd_age_nxt;
        fb_age_r  <= fb_age_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  `SSS_ASSERT_IMPL(a_goal_zero_no_cmd, out_valid_r && !out_data_r.command_valid,
                   out_data_r.goal_angle == 16'sd0)
  `SSS_ASSERT_IMPL(a_system_ok_parts, out_valid_r && out_data_r.system_ok,
                   out_data_r.servo_ok && out_data_r.limits_ok && !out_data_r.estop)
  `SSS_ASSERT_IMPL(a_pos_ok_healthy, out_valid_r && out_data_r.position_ok,
                   out_data_r.servo_ok)
  `SSS_ASSERT_IMPL(a_full_blocks_input, s1_valid_r && out_valid_r && !out_ready,
                   !in_ready)

endmodule

// ===== rtl/sss_regs.sv =====
// apb configuration registers of the steering safety supervisor
module sss_regs
  import sss_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output sss_cfg_t          cfg
);

  sss_cfg_t   cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_angle              <= MAX_ANGLE_RST;
      cfg_r.servo_id               <= SERVO_ID_RST;
      cfg_r.ilim_ma                <= CURRENT_LIM_RST;
      cfg_r.command_timeout_ticks  <= TIMEOUT_RST;
      cfg_r.feedback_timeout_ticks <= TIMEOUT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAX_ANGLE:   cfg_r.max_angle              <= pwdata[14:0];
        REG_SERVO_ID:    cfg_r.servo_id               <= pwdata[7:0];
        REG_CURRENT_LIM: cfg_r.ilim_ma                <= pwdata[15:0];
        REG_CMD_TIMEOUT: cfg_r.command_timeout_ticks  <= pwdata[15:0];
        REG_FB_TIMEOUT:  cfg_r.feedback_timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_ANGLE:   prdata = {17'd0, cfg_r.max_angle};
      REG_SERVO_ID:    prdata = {24'd0, cfg_r.servo_id};
      REG_CURRENT_LIM: prdata = {16'd0, cfg_r.ilim_ma};
      REG_CMD_TIMEOUT: prdata = {16'd0, cfg_r.command_timeout_ticks};
      REG_FB_TIMEOUT:  prdata = {16'd0, cfg_r.feedback_timeout_ticks};
      default:         prdata = 32'd0;
    endcase
  end

endmodule
